// ----- hdl/tgc_pkg.sv -----
`timescale 1ns / 1ps

package tgc_pkg;

   typedef enum logic [2:0] {
      ACT_IDLE   = 3'd0,
      ACT_DROOP  = 3'd1,
      ACT_HOME   = 3'd2,
      ACT_EAR1   = 3'd3,
      ACT_EAR2   = 3'd4,
      ACT_DANCE  = 3'd5
   } action_type;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TILT_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_DWELL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_DWELL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTER_WRAP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAY_HOLD      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DANCE_COUNT    = 3'd5;

   localparam logic [4:0] RST_TILT_THRESHOLD = 5'd10;
   localparam logic [7:0] RST_FORWARD_DWELL  = 8'd50;
   localparam logic [7:0] RST_TILT_DWELL     = 8'd10;
   localparam logic [7:0] RST_COUNTER_WRAP   = 8'd200;
   localparam logic [6:0] RST_SWAY_HOLD      = 7'd100;
   localparam logic [7:0] RST_DANCE_COUNT    = 8'd2;
   localparam logic [6:0] RST_LFSR           = 7'd1;

   typedef struct packed {
      logic [4:0] tilt_threshold;
      logic [7:0] forward_dwell;
      logic [7:0] tilt_dwell;
      logic [7:0] counter_wrap;
      logic [6:0] sway_hold;
      logic [7:0] dance_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0]        forward_count;
      logic [7:0]        backward_count;
      logic [7:0]        left_count;
      logic [7:0]        right_count;
      logic signed [7:0] memory;
      logic [7:0]        alternation_count;
      logic              drooped;
   } gesture_state_type;

   typedef struct packed {
      action_type action;
      logic       dance;
   } decision_type;

   // eight shifts of the 7-bit LFSR per dance step
   function automatic logic [6:0] lfsr_adv8(input logic [6:0] s);
      logic [6:0] t;
      t = s;
      for (int i = 0; i < 8; i++) begin
         t = {t[3] ^ t[0], t[6:1]};
      end
      return t;
   endfunction

endpackage

// ----- hdl/tgc_classify.sv -----
`timescale 1ns / 1ps

module tgc_classify (
   input  logic signed [5:0]          tilt_x,
   input  logic signed [5:0]          tilt_y,
   input  tgc_pkg::cfg_type           cfg,
   input  tgc_pkg::gesture_state_type cur,
   output tgc_pkg::gesture_state_type nxt,
   output tgc_pkg::decision_type      dec
);

   logic signed [6:0]   x_ext;
   logic signed [6:0]   y_ext;
   logic signed [6:0]   thr_pos;
   logic signed [6:0]   thr_neg;
   logic                fwd_hit;
   logic                bwd_hit;
   logic                left_hit;
   logic                right_hit;
   logic [7:0]          fwd_n;
   logic [7:0]          bwd_n;
   logic [7:0]          left_n;
   logic [7:0]          right_n;
   logic signed [7:0]   mem_mid;
   logic [7:0]          alt_mid;
   logic [7:0]          alt_inc;
   logic                drooped_n;
   tgc_pkg::action_type act;
   logic                dance;

   assign x_ext   = {tilt_x[5], tilt_x};
   assign y_ext   = {tilt_y[5], tilt_y};
   assign thr_pos = $signed({2'b00, cfg.tilt_threshold});
   assign thr_neg = -thr_pos;

   assign fwd_hit   = x_ext > thr_pos;
   assign bwd_hit   = x_ext < thr_neg;
   assign left_hit  = y_ext > thr_pos;
   assign right_hit = y_ext < thr_neg;

   // count up while tilted, drop to zero when not tilted or at the wrap value
   assign fwd_n   = (fwd_hit && cur.forward_count < cfg.counter_wrap) ?
                    cur.forward_count + 8'd1 : 8'd0;
   assign bwd_n   = (bwd_hit && cur.backward_count < cfg.counter_wrap) ?
                    cur.backward_count + 8'd1 : 8'd0;
   assign left_n  = (left_hit && cur.left_count < cfg.counter_wrap) ?
                    cur.left_count + 8'd1 : 8'd0;
   assign right_n = (right_hit && cur.right_count < cfg.counter_wrap) ?
                    cur.right_count + 8'd1 : 8'd0;

   assign alt_inc = (cur.alternation_count == 8'hFF) ? 8'hFF :
                    cur.alternation_count + 8'd1;

   always_comb begin
      act       = tgc_pkg::ACT_IDLE;
      dance     = 1'b0;
      mem_mid   = cur.memory;
      alt_mid   = cur.alternation_count;
      drooped_n = cur.drooped;
      if (fwd_n > cfg.forward_dwell) begin
         act       = tgc_pkg::ACT_DROOP;
         drooped_n = 1'b1;
         mem_mid   = 8'sd0;
      end else if (bwd_n > cfg.tilt_dwell) begin
         act     = tgc_pkg::ACT_HOME;
         mem_mid = 8'sd0;
      end else if (left_n > cfg.tilt_dwell) begin
         if (cur.memory < 8'sd0) begin
            alt_mid = alt_inc;
            dance   = alt_inc >= cfg.dance_count;
         end
         act     = tgc_pkg::ACT_EAR1;
         mem_mid = $signed({1'b0, cfg.sway_hold});
      end else if (right_n > cfg.tilt_dwell) begin
         if (cur.memory > 8'sd0) begin
            alt_mid = alt_inc;
            dance   = alt_inc >= cfg.dance_count;
         end
         act     = tgc_pkg::ACT_EAR2;
         mem_mid = -$signed({1'b0, cfg.sway_hold});
      end else begin
         act       = cur.drooped ? tgc_pkg::ACT_HOME : tgc_pkg::ACT_IDLE;
         drooped_n = 1'b0;
      end
   end

   always_comb begin
      nxt.forward_count     = fwd_n;
      nxt.backward_count    = bwd_n;
      nxt.left_count        = left_n;
      nxt.right_count       = right_n;
      nxt.drooped           = drooped_n;
      nxt.alternation_count = alt_mid;
      nxt.memory            = mem_mid;
      // memory decays toward zero; at zero the alternation run ends
      if (mem_mid > 8'sd0) begin
         nxt.memory = mem_mid - 8'sd1;
      end else if (mem_mid < 8'sd0) begin
         nxt.memory = mem_mid + 8'sd1;
      end else begin
         nxt.alternation_count = 8'd0;
      end
   end

   assign dec.action = act;
   assign dec.dance  = dance;

endmodule

// ----- hdl/tilt_gesture_classifier.sv -----
`timescale 1ns / 1ps
// The first result of an item is registered at accept and shows on rsp_ in the cycle after.
// Throughput: 1 item per cycle while results are taken; an item that starts a
// dance holds the single result register for DANCE_STEPS results, one LFSR
// advance per step, and req_ready stays low until its last step is taken.
// Reset (synchronous): config to defaults, counters and memory cleared, LFSR = 1.
module tilt_gesture_classifier #(
   parameter int DANCE_STEPS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [5:0]                     req_tilt_x,
   input  logic signed [5:0]                     req_tilt_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [2:0]                            rsp_action,
   output logic [5:0]                            rsp_ear_one_pos,
   output logic [6:0]                            rsp_ear_two_pos,
   output logic                                  rsp_last,
   input  logic                                  csr_we,
   input  logic [tgc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int STEP_W = $clog2(DANCE_STEPS + 1);

   tgc_pkg::cfg_type           cfg_ff;
   tgc_pkg::gesture_state_type state_ff;
   tgc_pkg::gesture_state_type state_in;
   tgc_pkg::decision_type      dec;
   logic [6:0]                 lfsr_ff;
   logic [6:0]                 lfsr_in;
   logic                       rsp_valid_ff;
   logic                       rsp_last_ff;
   logic [2:0]                 rsp_action_ff;
   logic [5:0]                 ear_one_ff;
   logic [6:0]                 ear_two_ff;
   logic [STEP_W-1:0]          steps_left_ff;
   logic                       accept;
   logic                       rsp_fire;
   logic                       next_step;

   tgc_classify u_classify (
      .tilt_x (req_tilt_x),
      .tilt_y (req_tilt_y),
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .nxt    (state_in),
      .dec    (dec)
   );

   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign req_ready = !rsp_valid_ff || (rsp_ready && rsp_last_ff);
   assign accept    = req_valid && req_ready;
   assign next_step = rsp_fire && !rsp_last_ff;
   assign lfsr_in   = tgc_pkg::lfsr_adv8(lfsr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tilt_threshold <= tgc_pkg::RST_TILT_THRESHOLD;
         cfg_ff.forward_dwell  <= tgc_pkg::RST_FORWARD_DWELL;
         cfg_ff.tilt_dwell     <= tgc_pkg::RST_TILT_DWELL;
         cfg_ff.counter_wrap   <= tgc_pkg::RST_COUNTER_WRAP;
         cfg_ff.sway_hold      <= tgc_pkg::RST_SWAY_HOLD;
         cfg_ff.dance_count    <= tgc_pkg::RST_DANCE_COUNT;
         state_ff              <= '0;
         lfsr_ff               <= tgc_pkg::RST_LFSR;
         rsp_valid_ff          <= 1'b0;
         rsp_last_ff           <= 1'b1;
         steps_left_ff         <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tgc_pkg::CSR_TILT_THRESHOLD: cfg_ff.tilt_threshold <= csr_wdata[4:0];
               tgc_pkg::CSR_FORWARD_DWELL:  cfg_ff.forward_dwell  <= csr_wdata;
               tgc_pkg::CSR_TILT_DWELL:     cfg_ff.tilt_dwell     <= csr_wdata;
               tgc_pkg::CSR_COUNTER_WRAP:   cfg_ff.counter_wrap   <= csr_wdata;
               tgc_pkg::CSR_SWAY_HOLD:      cfg_ff.sway_hold      <= csr_wdata[6:0];
               tgc_pkg::CSR_DANCE_COUNT:    cfg_ff.dance_count    <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
            if (dec.dance) begin
               lfsr_ff       <= lfsr_in;
               rsp_last_ff   <= (DANCE_STEPS == 1);
               steps_left_ff <= STEP_W'(DANCE_STEPS - 1);
            end else begin
               rsp_last_ff   <= 1'b1;
            end
         end else if (next_step) begin
            lfsr_ff       <= lfsr_in;
            rsp_last_ff   <= (steps_left_ff == STEP_W'(1));
            steps_left_ff <= steps_left_ff - STEP_W'(1);
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         if (dec.dance) begin
            rsp_action_ff <= tgc_pkg::ACT_DANCE;
            ear_one_ff    <= lfsr_in[5:0];
            ear_two_ff    <= 7'd64 - {1'b0, lfsr_in[5:0]};
         end else begin
            rsp_action_ff <= dec.action;
            ear_one_ff    <= 6'd0;
            ear_two_ff    <= 7'd0;
         end
      end else if (next_step) begin
         rsp_action_ff <= tgc_pkg::ACT_DANCE;
         ear_one_ff    <= lfsr_in[5:0];
         ear_two_ff    <= 7'd64 - {1'b0, lfsr_in[5:0]};
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_ear_one_pos = ear_one_ff;
   assign rsp_ear_two_pos = ear_two_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_accept_mid_dance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> !req_ready)
      else $error("item accepted while a dance is still being delivered");

   a_dance_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !rsp_last_ff |=>
         rsp_valid_ff && rsp_action_ff == tgc_pkg::ACT_DANCE)
      else $error("dance burst ended before its last step");

   a_ears_zero_off_dance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_action_ff != tgc_pkg::ACT_DANCE |->
         ear_one_ff == 6'd0 && ear_two_ff == 7'd0 && rsp_last_ff)
      else $error("non-dance result with ear data or without last");

   a_ears_complement: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_action_ff == tgc_pkg::ACT_DANCE |->
         ear_two_ff == 7'd64 - {1'b0, ear_one_ff})
      else $error("ear two is not the complement of ear one");
`endif

endmodule

// ----- verif/tilt_gesture_classifier_tb.sv -----
`timescale 1ns / 1ps

module tilt_gesture_classifier_tb;

   localparam int DANCE_STEPS = 10;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_REPORTS = 10;

   localparam logic [tgc_pkg::CSR_IDX_W-1:0] CSR_NO_REG = 3'd6;

   typedef struct {
      logic signed [5:0] x;
      logic signed [5:0] y;
   } tilt_sample_type;

   typedef struct {
      tgc_pkg::action_type action;
      logic [5:0]          ear_one;
      logic [6:0]          ear_two;
      logic                last;
   } ear_action_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [5:0] req_tilt_x = '0;
   logic signed [5:0] req_tilt_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_action;
   logic [5:0] rsp_ear_one_pos;
   logic [6:0] rsp_ear_two_pos;
   logic rsp_last;
   logic csr_we = 1'b0;
   logic [tgc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tgc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic hold_go = 1'b0;
   int hold_left = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int tick_count = 0;

   tilt_sample_type samples_to_send[$];
   ear_action_type queued_actions[$];

   // predictor copy of the configuration and gesture state
   int thr_cfg = int'(tgc_pkg::RST_TILT_THRESHOLD);
   int fwd_cfg = int'(tgc_pkg::RST_FORWARD_DWELL);
   int dwell_cfg = int'(tgc_pkg::RST_TILT_DWELL);
   int wrap_cfg = int'(tgc_pkg::RST_COUNTER_WRAP);
   int hold_cfg = int'(tgc_pkg::RST_SWAY_HOLD);
   int dance_cfg = int'(tgc_pkg::RST_DANCE_COUNT);
   int fwd_cnt = 0;
   int back_cnt = 0;
   int left_cnt = 0;
   int right_cnt = 0;
   int sway_mem = 0;
   int alt_cnt = 0;
   logic drooped = 1'b0;
   logic [6:0] lfsr_state = tgc_pkg::RST_LFSR;

   tilt_gesture_classifier #(.DANCE_STEPS(DANCE_STEPS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_tilt_x(req_tilt_x),
      .req_tilt_y(req_tilt_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_action(rsp_action),
      .rsp_ear_one_pos(rsp_ear_one_pos),
      .rsp_ear_two_pos(rsp_ear_two_pos),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int next_dwell(input bit cond, input int c);
      return (cond && c < wrap_cfg) ? c + 1 : 0;
   endfunction

   // one accepted sample -> one action, or a burst of dance steps
   function automatic void classify_tilt(input logic signed [5:0] sx,
                                         input logic signed [5:0] sy);
      int x;
      int y;
      tgc_pkg::action_type act;
      bit dance;
      ear_action_type r;
      x = int'(sx);
      y = int'(sy);
      dance = 1'b0;
      fwd_cnt = next_dwell(x > thr_cfg, fwd_cnt);
      back_cnt = next_dwell(x < -thr_cfg, back_cnt);
      left_cnt = next_dwell(y > thr_cfg, left_cnt);
      right_cnt = next_dwell(y < -thr_cfg, right_cnt);

      if (fwd_cnt > fwd_cfg) begin
         act = tgc_pkg::ACT_DROOP;
         drooped = 1'b1;
         sway_mem = 0;
      end else if (back_cnt > dwell_cfg) begin
         act = tgc_pkg::ACT_HOME;
         sway_mem = 0;
      end else if (left_cnt > dwell_cfg) begin
         if (sway_mem < 0) begin
            if (alt_cnt < 255) alt_cnt++;
            dance = alt_cnt >= dance_cfg;
         end
         act = tgc_pkg::ACT_EAR1;
         sway_mem = hold_cfg;
      end else if (right_cnt > dwell_cfg) begin
         if (sway_mem > 0) begin
            if (alt_cnt < 255) alt_cnt++;
            dance = alt_cnt >= dance_cfg;
         end
         act = tgc_pkg::ACT_EAR2;
         sway_mem = -hold_cfg;
      end else begin
         act = drooped ? tgc_pkg::ACT_HOME : tgc_pkg::ACT_IDLE;
         drooped = 1'b0;
      end

      if (sway_mem != 0) sway_mem += (sway_mem > 0) ? -1 : 1;
      else alt_cnt = 0;

      if (!dance) begin
         r.action = act;
         r.ear_one = '0;
         r.ear_two = '0;
         r.last = 1'b1;
         queued_actions.push_back(r);
      end else begin
         for (int k = 0; k < DANCE_STEPS; k++) begin
            repeat (8) lfsr_state = {lfsr_state[3] ^ lfsr_state[0], lfsr_state[6:1]};
            r.action = tgc_pkg::ACT_DANCE;
            r.ear_one = lfsr_state[5:0];
            r.ear_two = 7'd64 - {1'b0, lfsr_state[5:0]};
            r.last = (k == DANCE_STEPS - 1);
            queued_actions.push_back(r);
         end
      end
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   task automatic write_csr(input logic [tgc_pkg::CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[7:0];
      case (idx)
         tgc_pkg::CSR_TILT_THRESHOLD: thr_cfg = int'(val[4:0]);
         tgc_pkg::CSR_FORWARD_DWELL:  fwd_cfg = int'(val[7:0]);
         tgc_pkg::CSR_TILT_DWELL:     dwell_cfg = int'(val[7:0]);
         tgc_pkg::CSR_COUNTER_WRAP:   wrap_cfg = int'(val[7:0]);
         tgc_pkg::CSR_SWAY_HOLD:      hold_cfg = int'(val[6:0]);
         tgc_pkg::CSR_DANCE_COUNT:    dance_cfg = int'(val[7:0]);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_config(input int thr, input int fwd, input int dwell,
                                 input int wrap, input int hold, input int dance);
      write_csr(tgc_pkg::CSR_TILT_THRESHOLD, thr);
      write_csr(tgc_pkg::CSR_FORWARD_DWELL, fwd);
      write_csr(tgc_pkg::CSR_TILT_DWELL, dwell);
      write_csr(tgc_pkg::CSR_COUNTER_WRAP, wrap);
      write_csr(tgc_pkg::CSR_SWAY_HOLD, hold);
      write_csr(tgc_pkg::CSR_DANCE_COUNT, dance);
   endtask

   task automatic add_sample(input int x, input int y);
      tilt_sample_type s;
      s.x = x[5:0];
      s.y = y[5:0];
      samples_to_send.push_back(s);
   endtask

   function automatic int tilted_mag();
      return (thr_cfg >= 31) ? 31 : int'($urandom_range(31, thr_cfg + 1));
   endfunction

   function automatic int calm_val();
      return int'($urandom_range(2 * thr_cfg)) - thr_cfg;
   endfunction

   // one gesture: mostly well-formed head moves, some noise
   task automatic queue_gesture();
      int runs;
      int len;
      bit dir;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            dir = 1'($urandom_range(1));
            runs = int'($urandom_range(2, 6));
            for (int r = 0; r < runs; r++) begin
               len = int'($urandom_range(1, ((dwell_cfg < 4) ? dwell_cfg : 4) + 2));
               for (int j = 0; j < len; j++)
                  add_sample(calm_val(), dir ? tilted_mag() : -tilted_mag());
               dir = !dir;
            end
         end
         4: begin
            len = int'($urandom_range(1, ((fwd_cfg < 10) ? fwd_cfg : 10) + 3));
            for (int j = 0; j < len; j++) add_sample(tilted_mag(), calm_val());
         end
         5: begin
            len = int'($urandom_range(1, ((dwell_cfg < 4) ? dwell_cfg : 4) + 2));
            for (int j = 0; j < len; j++) add_sample(-tilted_mag(), calm_val());
         end
         6: begin
            len = int'($urandom_range(1, 3));
            for (int j = 0; j < len; j++) add_sample(calm_val(), calm_val());
         end
         default: begin
            len = int'($urandom_range(1, 3));
            for (int j = 0; j < len; j++)
               add_sample(int'($urandom_range(63)), int'($urandom_range(63)));
         end
      endcase
   endtask

   task automatic load_gestures(input int n);
      while (samples_to_send.size() < n) queue_gesture();
   endtask

   // strict left/right alternation; the index keeps the parity across chunks
   task automatic add_sway_run(input int first_i, input int last_i);
      for (int i = first_i; i <= last_i; i++)
         add_sample(calm_val(), (i % 2 == 0) ? tilted_mag() : -tilted_mag());
   endtask

   task automatic drain();
      do @(negedge clock);
      while (samples_to_send.size() != 0 || req_valid || queued_actions.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // driver: the payload holds until the item is taken
   always @(posedge clock) begin : drive_req
      tilt_sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) classify_tilt(req_tilt_x, req_tilt_y);
         if (!req_valid || req_ready) begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = samples_to_send.pop_front();
               req_tilt_x <= nxt.x;
               req_tilt_y <= nxt.y;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_go) hold_left <= HOLD_OFF_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      ear_action_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (queued_actions.size() == 0) begin
            note_failure($sformatf("unexpected item: action %0d ear1 %0d ear2 %0d last %0d",
                                   rsp_action, rsp_ear_one_pos, rsp_ear_two_pos, rsp_last));
         end else begin
            want = queued_actions.pop_front();
            if (rsp_action !== want.action || rsp_ear_one_pos !== want.ear_one ||
                rsp_ear_two_pos !== want.ear_two || rsp_last !== want.last)
               note_failure($sformatf(
                  "mismatch: expected action %0d ear1 %0d ear2 %0d last %0d, got %0d %0d %0d %0d",
                  want.action, want.ear_one, want.ear_two, want.last,
                  rsp_action, rsp_ear_one_pos, rsp_ear_two_pos, rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      tick_count <= tick_count + 1;
      if (tick_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // field extremes and threshold edges at reset settings
      set_idling(0, 0);
      add_sample(-32, -32);
      add_sample(31, 31);
      add_sample(0, 0);
      add_sample(-32, 31);
      add_sample(31, -32);
      add_sample(10, -10);
      add_sample(11, -11);
      add_sample(-11, 11);
      add_sample(21, -22);
      add_sample(-1, 1);
      drain();

      // every action: ear flicks, two dances, home, droop, home after droop
      program_config(10, 2, 0, 255, 3, 2);
      write_csr(CSR_NO_REG, 8'h5a);
      add_sample(0, 20);
      add_sample(0, -20);
      add_sample(0, 20);
      add_sample(0, -20);
      add_sample(-20, 0);
      add_sample(20, 0);
      add_sample(20, 0);
      add_sample(20, 0);
      add_sample(0, 0);
      add_sample(0, 0);
      drain();

      program_config(6, 5, 1, 8, 10, 3);
      load_gestures(12);
      drain();

      // zero threshold and dwells, zero dance count, hold masked to its width
      set_idling(73, 0);
      program_config(0, 0, 0, 255, 8'hff, 0);
      load_gestures(8);
      drain();

      // threshold masked to 31, wrap of 1
      set_idling(0, 73);
      program_config(8'hff, 255, 255, 1, 1, 1);
      load_gestures(6);
      drain();

      program_config($urandom_range(2, 12), $urandom_range(0, 8), $urandom_range(0, 3),
                     $urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(0, 4));
      load_gestures(8);
      drain();

      // zero wrap keeps every counter at 0
      set_idling(28, 28);
      program_config(4, 0, 0, 0, 20, 1);
      load_gestures(6);
      drain();

      // zero hold clears the sway memory right away
      program_config(4, 3, 0, 20, 0, 1);
      load_gestures(6);
      drain();

      // long alternation run drives the count into saturation; it is sent in
      // chunks under each idling mix, with a long receiver hold-off in the first
      set_idling(0, 0);
      program_config(5, 10, 0, 255, 127, 255);
      add_sway_run(0, 79);
      @(posedge clock);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      drain();

      set_idling(73, 0);
      add_sway_run(80, 139);
      drain();

      set_idling(0, 73);
      add_sway_run(140, 199);
      drain();

      set_idling(28, 28);
      add_sway_run(200, 257);
      drain();

      fail_count += queued_actions.size();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- tilt_gesture_classifier.f -----
hdl/tgc_pkg.sv
hdl/tgc_classify.sv
hdl/tilt_gesture_classifier.sv
verif/tilt_gesture_classifier_tb.sv
